### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while rst_n is low.
`define ASSERT_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_SYNC(label, !(cond), msg)

`endif

### hdl/dlc_pkg.sv
package dlc_pkg;

  localparam int ITEM_DEPTH = 2;

  localparam logic [3:0] MSG_LAST_IDX = 4'd8;
  localparam logic [3:0] LAST_IDX     = 4'd11;

  localparam logic [7:0] POLY_LOW       = 8'h1D;
  localparam logic [7:0] GEN_C2         = 8'h0E;
  localparam logic [7:0] GEN_C1         = 8'h38;
  localparam logic [7:0] GEN_C0         = 8'h40;
  localparam logic [7:0] MASK_RESET     = 8'h96;
  localparam logic [7:0] OPCODE_PRIVATE = 8'h03;
  localparam logic [7:0] OPCODE_GROUP   = 8'h00;

  localparam logic [1:0] OBUF_CNT_FULL = 2'd2;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [23:0] target_id;
    logic [23:0] source_id;
  } item_t;

  typedef struct packed {
    logic [7:0] lc_byte;
    logic [3:0] byte_index;
    logic       last;
  } obyte_t;

  // GF(2^8) multiply, field polynomial 0x11D
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ POLY_LOW) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

### hdl/dlc_front.sv
`include "assert_macros.svh"

module dlc_front #(
  parameter int ItemDepth = dlc_pkg::ITEM_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [23:0]     in_source_id,
  input  logic [23:0]     in_target_id,
  input  logic            in_private_call,
  output logic            in_full,
  output logic            item_valid,
  output dlc_pkg::item_t  item,
  input  logic            item_take
);
  import dlc_pkg::*;

  localparam int PtrW = (ItemDepth > 1) ? $clog2(ItemDepth) : 1;
  localparam int CntW = $clog2(ItemDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(ItemDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(ItemDepth);

  item_t           mem_r [ItemDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push_fire;
  logic            take_fire;
  item_t           new_item;

  assign in_full    = (cnt_r == CntFull);
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rd_ptr_r];
  assign push_fire  = in_push && !in_full;
  assign take_fire  = item_take && item_valid;

  always_comb begin
    new_item.opcode    = in_private_call ? OPCODE_PRIVATE : OPCODE_GROUP;
    new_item.target_id = in_target_id;
    new_item.source_id = in_source_id;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !take_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (take_fire && !push_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  `ASSERT_NEVER(a_item_cnt_over, cnt_r > CntFull, "item queue count above depth")
  `ASSERT_SYNC(a_item_cnt_up,
    (push_fire && !take_fire) |=> (cnt_r == $past(cnt_r) + 1'b1),
    "item queue count did not rise on transfer in")
  `ASSERT_SYNC(a_take_valid, item_take |-> item_valid, "item taken from empty queue")

endmodule

### hdl/dlc_back.sv
`include "assert_macros.svh"

module dlc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      parity_mask,
  input  logic            item_valid,
  input  dlc_pkg::item_t  item,
  output logic            item_take,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_lc_byte,
  output logic [3:0]      out_byte_index,
  output logic            out_last
);
  import dlc_pkg::*;

  logic       busy_r, busy_nxt;
  logic [3:0] idx_r, idx_nxt;
  item_t      cur_r, cur_nxt;
  logic [7:0] r0_r, r0_nxt;
  logic [7:0] r1_r, r1_nxt;
  logic [7:0] r2_r, r2_nxt;

  obyte_t     obuf_r [2];
  logic       owr_r, owr_nxt;
  logic       ord_r, ord_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;

  logic       ofull;
  logic       pop_fire;
  logic       adv;
  logic       at_last;
  logic       is_msg;
  logic       load;
  logic [7:0] msg_byte;
  logic [7:0] fb;
  logic [7:0] cur_byte;
  obyte_t     wr_entry;

  assign ofull    = (ocnt_r == OBUF_CNT_FULL);
  assign out_empty = (ocnt_r == 2'd0);
  assign pop_fire = out_pop && !out_empty;
  assign adv      = busy_r && !ofull;
  assign at_last  = (idx_r == LAST_IDX);
  assign is_msg   = (idx_r <= MSG_LAST_IDX);
  assign load     = item_valid && (!busy_r || (adv && at_last));
  assign item_take = load;

  always_comb begin
    case (idx_r)
      4'd0:    msg_byte = cur_r.opcode;
      4'd3:    msg_byte = cur_r.target_id[23:16];
      4'd4:    msg_byte = cur_r.target_id[15:8];
      4'd5:    msg_byte = cur_r.target_id[7:0];
      4'd6:    msg_byte = cur_r.source_id[23:16];
      4'd7:    msg_byte = cur_r.source_id[15:8];
      4'd8:    msg_byte = cur_r.source_id[7:0];
      default: msg_byte = 8'h00;
    endcase
  end

  assign fb       = msg_byte ^ r2_r;
  assign cur_byte = is_msg ? msg_byte : (r2_r ^ parity_mask);

  always_comb begin
    wr_entry.lc_byte    = cur_byte;
    wr_entry.byte_index = idx_r;
    wr_entry.last       = at_last;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    cur_nxt  = cur_r;
    r0_nxt   = r0_r;
    r1_nxt   = r1_r;
    r2_nxt   = r2_r;
    if (adv) begin
      idx_nxt = idx_r + 1'b1;
      if (is_msg) begin
        r2_nxt = r1_r ^ gf_mul(GEN_C2, fb);
        r1_nxt = r0_r ^ gf_mul(GEN_C1, fb);
        r0_nxt = gf_mul(GEN_C0, fb);
      end else begin
        r2_nxt = r1_r;
        r1_nxt = r0_r;
        r0_nxt = 8'h00;
      end
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
      cur_nxt  = item;
      r0_nxt   = 8'h00;
      r1_nxt   = 8'h00;
      r2_nxt   = 8'h00;
    end
  end

  always_comb begin
    owr_nxt  = adv ? ~owr_r : owr_r;
    ord_nxt  = pop_fire ? ~ord_r : ord_r;
    ocnt_nxt = ocnt_r;
    if (adv && !pop_fire) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (pop_fire && !adv) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    if (adv) begin
      obuf_r[owr_r] <= wr_entry;
    end
  end

  assign out_lc_byte    = obuf_r[ord_r].lc_byte;
  assign out_byte_index = obuf_r[ord_r].byte_index;
  assign out_last       = obuf_r[ord_r].last;

  `ASSERT_SYNC(a_idx_range, busy_r |-> (idx_r <= LAST_IDX), "byte index past end of word")
  `ASSERT_NEVER(a_obuf_over, ocnt_r > OBUF_CNT_FULL, "output buffer count above depth")
  `ASSERT_SYNC(a_drain_idle, (adv && at_last && !item_valid) |=> !busy_r, "sequencer busy after last byte with no item")

endmodule

### hdl/dmr_voice_lc_rs129_encoder.sv
// DMR Full Link Control encoder with RS(12,9) parity.
// Input channel: present source/target IDs and private_call with in_push;
// a transfer happens on a clock edge with in_push high and in_full low.
// A small item queue (ItemDepth deep) sits in front of the byte sequencer.
// Result channel: while out_empty is low the oldest byte is on out_lc_byte,
// out_byte_index and out_last; out_pop high takes it. Twelve bytes per item,
// index 0 to 11, out_last on byte 11; bytes 9-11 are parity XOR cfg mask.
// Path to the first byte: item queue, sequencer registers, output buffer.
// Throughput: one byte per cycle unless the output buffer is full, set by the
// sequencer that emits one byte and runs one RS shift-register step a cycle.
// A 2-entry output buffer lets the sequencer run while the receiver stalls;
// on a stall the sequencer, then the item queue, fill and in_full rises.
// cfg_we writes cfg_wdata into the parity mask; write only while idle.
// Reset (rst_n low, synchronous) empties both queues and sets mask to 0x96.
module dmr_voice_lc_rs129_encoder #(
  parameter int ItemDepth = dlc_pkg::ITEM_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_push,
  input  logic [23:0] in_source_id,
  input  logic [23:0] in_target_id,
  input  logic        in_private_call,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_lc_byte,
  output logic [3:0]  out_byte_index,
  output logic        out_last
);
  import dlc_pkg::*;

  logic [7:0] mask_r, mask_nxt;
  logic       item_valid;
  item_t      item;
  logic       item_take;

  assign mask_nxt = cfg_we ? cfg_wdata : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  dlc_front #(
    .ItemDepth(ItemDepth)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_source_id    (in_source_id),
    .in_target_id    (in_target_id),
    .in_private_call (in_private_call),
    .in_full         (in_full),
    .item_valid      (item_valid),
    .item            (item),
    .item_take       (item_take)
  );

  dlc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .parity_mask    (mask_r),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_lc_byte    (out_lc_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule
